/* hdl/vectorscope_point_mapper_top_defines.svh */
// Assertion helpers shared by the vectorscope mapper RTL.
`ifndef VECTORSCOPE_POINT_MAPPER_TOP_DEFINES_SVH
`define VECTORSCOPE_POINT_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication.
`define VSPM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VSPM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vspm_pkg.sv */
package vspm_pkg;

  localparam int HALF_CANVAS   = 512;
  localparam int DIV_UV_STEPS  = 20;
  localparam int DIV_C_STEPS   = 8;
  localparam int NUM_STAGES    = 1 + DIV_UV_STEPS + 6 + DIV_C_STEPS;

  typedef enum logic [2:0] {
    REG_AREA_X_FIRST = 3'd0,
    REG_AREA_X_LAST  = 3'd1,
    REG_AREA_Y_FIRST = 3'd2,
    REG_AREA_Y_LAST  = 3'd3,
    REG_FIELD_SELECT = 3'd4,
    REG_PLOT_MODE    = 3'd5,
    REG_IRE_RANGE    = 3'd6
  } reg_idx_t;

  localparam logic [1:0] FIELD_FIRST  = 2'd1;
  localparam logic [1:0] FIELD_SECOND = 2'd2;

  localparam logic [7:0] ALPHA_DENSITY = 8'd14;
  localparam logic [7:0] ALPHA_FULL    = 8'd255;

  typedef struct packed {
    logic [10:0]        area_x_first;
    logic [10:0]        area_x_last;
    logic [9:0]         area_y_first;
    logic [9:0]         area_y_last;
    logic [1:0]         field_select;
    logic [2:0]         plot_mode;
    logic signed [16:0] ire_range;
  } cfg_t;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic       ok;
    logic       multi;
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

endpackage

/* hdl/vspm_ifs.sv */
interface vspm_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] chroma_u;
  logic signed [17:0] chroma_v;
  logic [9:0]         line_index;
  logic [10:0]        column_index;
  modport source (output valid, chroma_u, chroma_v, line_index, column_index, input ready);
  modport sink   (input valid, chroma_u, chroma_v, line_index, column_index, output ready);
endinterface

interface vspm_out_if;
  logic       valid;
  logic       ready;
  logic       plot_valid;
  logic [9:0] canvas_x;
  logic [9:0] canvas_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, plot_valid, canvas_x, canvas_y, red, green, blue, alpha,
                  input ready);
  modport sink   (input valid, plot_valid, canvas_x, canvas_y, red, green, blue, alpha,
                  output ready);
endinterface

interface vspm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface vspm_item_if;
  logic            valid;
  logic            ready;
  vspm_pkg::item_t item;
  modport source (output valid, item, input ready);
  modport sink   (input valid, item, output ready);
endinterface

/* hdl/vectorscope_point_mapper_top.sv */
// Vectorscope point mapper.
// Channels: "in" takes one chroma word (U, V, line, column) per handshake;
// "out" returns one result word per input word, in order: plot flag,
// canvas position, trace colour and alpha. "cfg" writes the seven control
// registers (index 0..6, others ignored); it is always ready.
// A word is moved when valid and ready are high at a rising clk edge.
// Throughput: one word per clock while the receiver keeps ready high. The
// word lands in the front queue at the accept edge, then passes 35 back
// pipeline stages (one setup stage, 20 steps of the U/V divide by IRE range,
// six arithmetic stages, 8 steps of the colour normalize divide) and the
// output register.
// While a result word waits and ready is low, the whole back pipeline holds
// and the two-word queue fills; input ready falls once the queue is full.
// Reset (rst, synchronous) empties the queue and pipeline and returns the
// registers to the full area, both fields, fixed colour, IRE range zero.
// The user must write registers only with no words in flight; unchecked.
module vectorscope_point_mapper_top (
  input logic         clk,
  input logic         rst,
  vspm_in_if.sink     in,
  vspm_out_if.source  out,
  vspm_cfg_if.sink    cfg
);

  vspm_pkg::cfg_t     regs;
  vspm_pkg::reg_idx_t widx;

  vspm_item_if        fq ();
  vspm_item_if        qb ();

  assign cfg.ready = 1'b1;
  assign widx      = vspm_pkg::reg_idx_t'(cfg.index);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.area_x_first <= 11'd0;
      regs.area_x_last  <= 11'd2047;
      regs.area_y_first <= 10'd0;
      regs.area_y_last  <= 10'd1023;
      regs.field_select <= 2'd0;
      regs.plot_mode    <= 3'd0;
      regs.ire_range    <= 17'sd0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (widx)
        vspm_pkg::REG_AREA_X_FIRST: regs.area_x_first <= cfg.data[10:0];
        vspm_pkg::REG_AREA_X_LAST:  regs.area_x_last  <= cfg.data[10:0];
        vspm_pkg::REG_AREA_Y_FIRST: regs.area_y_first <= cfg.data[9:0];
        vspm_pkg::REG_AREA_Y_LAST:  regs.area_y_last  <= cfg.data[9:0];
        vspm_pkg::REG_FIELD_SELECT: regs.field_select <= cfg.data[1:0];
        vspm_pkg::REG_PLOT_MODE:    regs.plot_mode    <= cfg.data[2:0];
        vspm_pkg::REG_IRE_RANGE:    regs.ire_range    <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // front: classify sample, pick fixed colour
  vspm_front u_front (
    .in  (in),
    .q   (fq.source),
    .cfg (regs)
  );

  vspm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (fq.sink),
    .pop  (qb.source)
  );

  // back: multicolour arithmetic and output register
  vspm_back u_back (
    .clk (clk),
    .rst (rst),
    .q   (qb.sink),
    .out (out),
    .cfg (regs)
  );

endmodule

/* hdl/vspm_front.sv */
// Area / field / canvas checks and fixed colour choice.
module vspm_front (
  vspm_in_if.sink      in,
  vspm_item_if.source  q,
  input vspm_pkg::cfg_t cfg
);

  logic signed [17:0] ub, vb, uq, vq;
  logic [12:0]        xs, ys;
  logic [10:0]        xl;
  logic [9:0]         yl;
  logic               in_area, field_ok, on_canvas, blend, density, multi, parity;
  vspm_pkg::item_t    it;

  assign in.ready = q.ready;
  assign q.valid  = in.valid;
  assign q.item   = it;

  always_comb begin
    // divide by 64, truncated toward zero
    ub = in.chroma_u + (in.chroma_u[17] ? 18'sd63 : 18'sd0);
    vb = in.chroma_v + (in.chroma_v[17] ? 18'sd63 : 18'sd0);
    uq = ub >>> 6;
    vq = vb >>> 6;
    xs = 13'd512 + {uq[11], uq[11:0]};
    ys = 13'd512 - {vq[11], vq[11:0]};
    on_canvas = (xs[12:10] == 3'd0) && (ys[12:10] == 3'd0);

    xl = (cfg.area_x_last < cfg.area_x_first) ? cfg.area_x_first : cfg.area_x_last;
    yl = (cfg.area_y_last < cfg.area_y_first) ? cfg.area_y_first : cfg.area_y_last;
    in_area = (in.column_index >= cfg.area_x_first) && (in.column_index <= xl) &&
              (in.line_index >= cfg.area_y_first) && (in.line_index <= yl);

    parity   = in.line_index[0];
    field_ok = !((cfg.field_select == vspm_pkg::FIELD_FIRST) && parity) &&
               !((cfg.field_select == vspm_pkg::FIELD_SECOND) && !parity);

    blend   = cfg.plot_mode[0];
    density = cfg.plot_mode[1];
    multi   = cfg.plot_mode[2];

    it       = '0;
    it.ok    = in_area && field_ok && on_canvas;
    it.x     = xs[9:0];
    it.y     = ys[9:0];
    it.alpha = density ? vspm_pkg::ALPHA_DENSITY : vspm_pkg::ALPHA_FULL;
    it.green = 8'd255;
    if (multi) begin
      // non-positive IRE range falls back to green
      it.multi = (cfg.ire_range > 17'sd0);
    end else if (cfg.field_select == vspm_pkg::FIELD_SECOND) begin
      it.blue = 8'd255;
    end else if (cfg.field_select == vspm_pkg::FIELD_FIRST) begin
      it.red = 8'd255;
    end else if (blend || density) begin
      it.red  = parity ? 8'd0 : 8'd255;
      it.blue = parity ? 8'd255 : 8'd0;
    end
    if (!it.ok) begin
      it = '0;
    end
  end

endmodule

/* hdl/vspm_queue.sv */
`include "vectorscope_point_mapper_top_defines.svh"

// Two-word skid queue between front and back.
module vspm_queue (
  input  logic        clk,
  input  logic        rst,
  vspm_item_if.sink   push,
  vspm_item_if.source pop
);

  vspm_pkg::item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign push.ready = (cnt != 2'd2);
  assign pop.valid  = (cnt != 2'd0);
  assign pop.item   = mem[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.item;
    end
  end

  `VSPM_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, cnt <= 2'd2, "queue overfilled")
  `VSPM_ASSERT_NXT(a_cnt_up, clk, rst, do_push && !do_pop, cnt == $past(cnt) + 2'd1, "push lost")
  `VSPM_ASSERT_NXT(a_cnt_dn, clk, rst, do_pop && !do_push, cnt == $past(cnt) - 2'd1, "pop lost")

endmodule

/* hdl/vspm_back.sv */
`include "vectorscope_point_mapper_top_defines.svh"

// Multicolour pipeline: UV divide by IRE range, inverse matrix, normalize.
module vspm_back (
  input  logic          clk,
  input  logic          rst,
  vspm_item_if.sink     q,
  vspm_out_if.source    out,
  input vspm_pkg::cfg_t cfg
);

  typedef struct packed {
    vspm_pkg::item_t    it;
    logic               su, sv, ovu, ovv;
    logic [16:0]        ru, rv;
    logic [19:0]        qu, qv;
    logic signed [19:0] un, vn;
    logic signed [39:0] pa, pb;
    logic signed [19:0] r, b;
    logic [16:0]        m;
    logic               dim;
    logic [2:0][16:0]   dr;
    logic [2:0][7:0]    nlo;
    logic [2:0][7:0]    dq;
  } pipe_t;

  localparam int NS = vspm_pkg::NUM_STAGES;
  localparam int SA = vspm_pkg::DIV_UV_STEPS + 1;

  pipe_t            st [NS];
  pipe_t            nx [NS];
  logic [NS-1:0]    vld;
  logic             en;
  logic [15:0]      dvs;

  assign dvs     = cfg.ire_range[15:0];
  assign en      = !out.valid || out.ready;
  assign q.ready = en;

  function automatic logic signed [23:0] trunc16(input logic signed [39:0] p);
    logic signed [39:0] t;
    t = p + (p[39] ? 40'sd65535 : 40'sd0);
    return t[39:16];
  endfunction

  function automatic logic signed [19:0] sat416(input logic signed [25:0] v);
    if (v > 26'sd524287) return 20'sd524287;
    if (v < -26'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic logic [16:0] clampq1(input logic signed [19:0] v);
    if (v < 20'sd0) return 17'd0;
    if (v > 20'sd65536) return 17'd65536;
    return v[16:0];
  endfunction

  function automatic pipe_t f_init(input vspm_pkg::item_t it, input logic [15:0] d);
    pipe_t      p;
    logic [9:0] au, av;
    p     = '0;
    p.it  = it;
    p.su  = !it.x[9];
    p.sv  = (it.y > 10'd512);
    au    = p.su ? 10'd512 - it.x : it.x - 10'd512;
    av    = p.sv ? it.y - 10'd512 : 10'd512 - it.y;
    // quotient reaches 2^20 exactly when 4*a >= divisor
    p.ovu = {4'd0, au, 2'b00} >= d;
    p.ovv = {4'd0, av, 2'b00} >= d;
    p.ru  = p.ovu ? 17'd0 : {5'd0, au, 2'b00};
    p.rv  = p.ovv ? 17'd0 : {5'd0, av, 2'b00};
    return p;
  endfunction

  function automatic pipe_t f_div(input pipe_t pi, input logic [15:0] d);
    pipe_t       p;
    logic [17:0] tu, tv;
    p  = pi;
    tu = {pi.ru, 1'b0};
    tv = {pi.rv, 1'b0};
    if (tu >= {2'b00, d}) begin
      tu   = tu - {2'b00, d};
      p.qu = {pi.qu[18:0], 1'b1};
    end else begin
      p.qu = {pi.qu[18:0], 1'b0};
    end
    if (tv >= {2'b00, d}) begin
      tv   = tv - {2'b00, d};
      p.qv = {pi.qv[18:0], 1'b1};
    end else begin
      p.qv = {pi.qv[18:0], 1'b0};
    end
    p.ru = tu[16:0];
    p.rv = tv[16:0];
    return p;
  endfunction

  function automatic logic signed [19:0] signq(input logic s, input logic ov,
                                               input logic [19:0] q);
    if (!s) begin
      return (ov || q[19]) ? 20'sd524287 : $signed(q);
    end
    return (ov || (q[19] && (q[18:0] != 19'd0))) ? -20'sd524288 : -$signed(q);
  endfunction

  function automatic pipe_t f_sel(input pipe_t pi);
    pipe_t p;
    p    = pi;
    p.un = signq(pi.su, pi.ovu, pi.qu);
    p.vn = signq(pi.sv, pi.ovv, pi.qv);
    return p;
  endfunction

  function automatic pipe_t f_mul1(input pipe_t pi);
    pipe_t p;
    p    = pi;
    p.pa = 40'(pi.vn) * 40'sd74703;
    p.pb = 40'(pi.un) * 40'sd133173;
    return p;
  endfunction

  function automatic pipe_t f_rb(input pipe_t pi);
    pipe_t p;
    p   = pi;
    p.r = sat416(26'sd32768 + 26'(trunc16(pi.pa)));
    p.b = sat416(26'sd32768 + 26'(trunc16(pi.pb)));
    return p;
  endfunction

  function automatic pipe_t f_mul2(input pipe_t pi);
    pipe_t p;
    p    = pi;
    p.pa = 40'(pi.r) * 40'sd33382;
    p.pb = 40'(pi.b) * 40'sd12728;
    return p;
  endfunction

  function automatic pipe_t f_gc(input pipe_t pi);
    pipe_t              p;
    logic signed [19:0] g;
    logic [16:0]        cr, cg, cb, m;
    p  = pi;
    g  = sat416(26'sd55823 - 26'(trunc16(pi.pa)) - 26'(trunc16(pi.pb)));
    cr = clampq1(pi.r);
    cg = clampq1(g);
    cb = clampq1(pi.b);
    m  = cr;
    if (cg > m) m = cg;
    if (cb > m) m = cb;
    p.m       = m;
    p.dim     = (m <= 17'd65);
    p.dr[0]   = cr;
    p.dr[1]   = cg;
    p.dr[2]   = cb;
    return p;
  endfunction

  // numerator c*255; its top bits start the remainder, below m
  function automatic pipe_t f_ninit(input pipe_t pi);
    pipe_t       p;
    logic [24:0] n;
    p = pi;
    for (int k = 0; k < 3; k++) begin
      n        = {pi.dr[k], 8'd0} - {8'd0, pi.dr[k]};
      p.dr[k]  = n[24:8];
      p.nlo[k] = n[7:0];
      p.dq[k]  = 8'd0;
    end
    return p;
  endfunction

  function automatic pipe_t f_div3(input pipe_t pi);
    pipe_t       p;
    logic [17:0] t;
    p = pi;
    for (int k = 0; k < 3; k++) begin
      t = {pi.dr[k], pi.nlo[k][7]};
      if (t >= {1'b0, pi.m}) begin
        t       = t - {1'b0, pi.m};
        p.dq[k] = {pi.dq[k][6:0], 1'b1};
      end else begin
        p.dq[k] = {pi.dq[k][6:0], 1'b0};
      end
      p.dr[k]  = t[16:0];
      p.nlo[k] = {pi.nlo[k][6:0], 1'b0};
    end
    return p;
  endfunction

  assign nx[0] = f_init(q.item, dvs);

  for (genvar i = 1; i < NS; i++) begin : g_stage
    if (i < SA) begin : g_div
      assign nx[i] = f_div(st[i-1], dvs);
    end else if (i == SA) begin : g_sel
      assign nx[i] = f_sel(st[i-1]);
    end else if (i == SA + 1) begin : g_mul1
      assign nx[i] = f_mul1(st[i-1]);
    end else if (i == SA + 2) begin : g_rb
      assign nx[i] = f_rb(st[i-1]);
    end else if (i == SA + 3) begin : g_mul2
      assign nx[i] = f_mul2(st[i-1]);
    end else if (i == SA + 4) begin : g_gc
      assign nx[i] = f_gc(st[i-1]);
    end else if (i == SA + 5) begin : g_ninit
      assign nx[i] = f_ninit(st[i-1]);
    end else begin : g_div3
      assign nx[i] = f_div3(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], q.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  // output register
  pipe_t      last;
  logic [7:0] red_next, green_next, blue_next;

  assign last = st[NS-1];

  always_comb begin
    red_next   = last.it.red;
    green_next = last.it.green;
    blue_next  = last.it.blue;
    if (last.it.multi) begin
      red_next   = last.dim ? 8'd255 : last.dq[0];
      green_next = last.dim ? 8'd255 : last.dq[1];
      blue_next  = last.dim ? 8'd255 : last.dq[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.plot_valid <= last.it.ok;
      out.canvas_x   <= last.it.x;
      out.canvas_y   <= last.it.y;
      out.red        <= red_next;
      out.green      <= green_next;
      out.blue       <= blue_next;
      out.alpha      <= last.it.alpha;
    end
  end

  `VSPM_ASSERT_IMP(a_reject_zero, clk, rst, out.valid && !out.plot_valid, (out.canvas_x == 10'd0) && (out.alpha == 8'd0) && (out.red == 8'd0) && (out.green == 8'd0) && (out.blue == 8'd0), "rejected word not cleared")
  `VSPM_ASSERT_IMP(a_alpha, clk, rst, out.valid && out.plot_valid, (out.alpha == vspm_pkg::ALPHA_DENSITY) || (out.alpha == vspm_pkg::ALPHA_FULL), "bad alpha")
  `VSPM_ASSERT_NXT(a_hold, clk, rst, !en, $stable(vld), "pipeline moved while stalled")

endmodule

/* verif/vspm_tb_pkg.sv */
package vspm_tb_pkg;

  import vspm_pkg::*;

  typedef struct packed {
    logic       plot_valid;
    logic [9:0] canvas_x;
    logic [9:0] canvas_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } plot_point_t;

  typedef struct packed {
    logic signed [17:0] chroma_u;
    logic signed [17:0] chroma_v;
    logic [9:0]         line_index;
    logic [10:0]        column_index;
  } sample_t;

endpackage

/* verif/tb.sv */
module tb;

  import vspm_pkg::*;
  import vspm_tb_pkg::*;

  localparam int LATENCY = 37;

  logic clk;
  logic rst;

  vspm_in_if  in_ch ();
  vspm_out_if out_ch ();
  vspm_cfg_if cfg_ch ();

  vectorscope_point_mapper_top dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the control registers.
  logic [10:0]        sh_x_first, sh_x_last;
  logic [9:0]         sh_y_first, sh_y_last;
  logic [1:0]         sh_field;
  logic [2:0]         sh_mode;
  logic signed [16:0] sh_ire;

  plot_point_t expected_points[$];
  int          errors;
  int          words_sent;
  int          points_plotted;
  int          multi_points;
  bit          no_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Saturate to signed Q4.16.
  function automatic longint sat_q416(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint clamp_q116(input longint v);
    if (v < 0) return 0;
    if (v > 65536) return 65536;
    return v;
  endfunction

  // Expected result for one sample under the shadow registers.
  function automatic plot_point_t map_sample(input sample_t s);
    plot_point_t p;
    int  xf, xl, yf, yl, px, py;
    bit  ok, parity, blend, density;
    longint du, dv, un, vn, r, g, b, m;
    xf = sh_x_first;
    xl = (sh_x_last < sh_x_first) ? sh_x_first : sh_x_last;
    yf = sh_y_first;
    yl = (sh_y_last < sh_y_first) ? sh_y_first : sh_y_last;
    parity = s.line_index[0];
    blend = sh_mode[0];
    density = sh_mode[1];
    // SV integer division truncates toward zero, as needed here.
    px = HALF_CANVAS + int'(s.chroma_u) / 64;
    py = HALF_CANVAS - int'(s.chroma_v) / 64;
    ok = 1'b1;
    if (s.column_index < xf || s.column_index > xl) ok = 1'b0;
    if (s.line_index < yf || s.line_index > yl) ok = 1'b0;
    if (sh_field == FIELD_FIRST && parity) ok = 1'b0;
    if (sh_field == FIELD_SECOND && !parity) ok = 1'b0;
    if (px < 0 || px >= 1024 || py < 0 || py >= 1024) ok = 1'b0;
    p = '0;
    if (!ok) return p;
    p.plot_valid = 1'b1;
    p.canvas_x = px[9:0];
    p.canvas_y = py[9:0];
    p.alpha = density ? ALPHA_DENSITY : ALPHA_FULL;
    if (sh_mode[2]) begin
      if (sh_ire <= 0) begin
        p.red = 0; p.green = 255; p.blue = 0;
      end else begin
        du = longint'(px - HALF_CANVAS) * 64;
        dv = longint'(HALF_CANVAS - py) * 64;
        un = sat_q416(du * 65536 / longint'(sh_ire));
        vn = sat_q416(dv * 65536 / longint'(sh_ire));
        r = sat_q416(32768 + vn * 74703 / 65536);
        b = sat_q416(32768 + un * 133173 / 65536);
        g = sat_q416(55823 - r * 33382 / 65536 - b * 12728 / 65536);
        r = clamp_q116(r);
        g = clamp_q116(g);
        b = clamp_q116(b);
        m = r;
        if (g > m) m = g;
        if (b > m) m = b;
        if (m > 65) begin
          p.red = 8'(r * 255 / m);
          p.green = 8'(g * 255 / m);
          p.blue = 8'(b * 255 / m);
        end else begin
          p.red = 255; p.green = 255; p.blue = 255;
        end
      end
    end else if (sh_field == FIELD_SECOND) begin
      p.red = 0; p.green = 255; p.blue = 255;
    end else if (sh_field == FIELD_FIRST) begin
      p.red = 255; p.green = 255; p.blue = 0;
    end else if (blend || density) begin
      p.red = parity ? 8'd0 : 8'd255;
      p.green = 255;
      p.blue = parity ? 8'd255 : 8'd0;
    end else begin
      p.red = 0; p.green = 255; p.blue = 0;
    end
    return p;
  endfunction

  // Register write; only called with nothing in flight.
  task automatic write_reg(input reg_idx_t idx, input logic [16:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_AREA_X_FIRST: sh_x_first = data[10:0];
      REG_AREA_X_LAST:  sh_x_last  = data[10:0];
      REG_AREA_Y_FIRST: sh_y_first = data[9:0];
      REG_AREA_Y_LAST:  sh_y_last  = data[9:0];
      REG_FIELD_SELECT: sh_field   = data[1:0];
      REG_PLOT_MODE:    sh_mode    = data[2:0];
      REG_IRE_RANGE:    sh_ire     = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_area(input int xf, xl, yf, yl);
    write_reg(REG_AREA_X_FIRST, 17'(xf));
    write_reg(REG_AREA_X_LAST, 17'(xl));
    write_reg(REG_AREA_Y_FIRST, 17'(yf));
    write_reg(REG_AREA_Y_LAST, 17'(yl));
  endtask

  // Send one sample word; random gap before it unless gaps are off.
  // Valid stays up for a following word; drain() drops it.
  task automatic send_sample(input sample_t s, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.chroma_u     <= s.chroma_u;
    in_ch.chroma_v     <= s.chroma_v;
    in_ch.line_index   <= s.line_index;
    in_ch.column_index <= s.column_index;
    do @(posedge clk); while (!in_ch.ready);
    expected_points.push_back(map_sample(s));
    words_sent++;
    @(negedge clk);
  endtask

  function automatic sample_t make_sample(input int u, v, line, col);
    sample_t s;
    s.chroma_u = 18'(u);
    s.chroma_v = 18'(v);
    s.line_index = 10'(line);
    s.column_index = 11'(col);
    return s;
  endfunction

  // Mostly on-canvas chroma, some full-range values.
  function automatic sample_t rand_sample();
    sample_t s;
    s = sample_t'(57'({$urandom, $urandom}));
    if ($urandom_range(0, 3) != 0) begin
      s.chroma_u = 18'($signed($urandom_range(0, 65535)) - 32768);
      s.chroma_v = 18'($signed($urandom_range(0, 65535)) - 32768);
    end
    return s;
  endfunction

  // Wait until every expected word is back, plus the pipeline depth.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Receiver: random ready stalls, compare each word with the oldest expectation.
  initial begin
    int stall;
    plot_point_t got, want;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) || rst);
      got = '{out_ch.plot_valid, out_ch.canvas_x, out_ch.canvas_y, out_ch.red,
              out_ch.green, out_ch.blue, out_ch.alpha};
      if (expected_points.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.plot_valid) points_plotted++;
        if (got.plot_valid != want.plot_valid) begin
          $error("plot_valid exp %0d got %0d", want.plot_valid, got.plot_valid); errors++;
        end
        if (got.canvas_x != want.canvas_x) begin
          $error("canvas_x exp %0d got %0d", want.canvas_x, got.canvas_x); errors++;
        end
        if (got.canvas_y != want.canvas_y) begin
          $error("canvas_y exp %0d got %0d", want.canvas_y, got.canvas_y); errors++;
        end
        if (got.red != want.red) begin
          $error("red exp %0d got %0d", want.red, got.red); errors++;
        end
        if (got.green != want.green) begin
          $error("green exp %0d got %0d", want.green, got.green); errors++;
        end
        if (got.blue != want.blue) begin
          $error("blue exp %0d got %0d", want.blue, got.blue); errors++;
        end
        if (got.alpha != want.alpha) begin
          $error("alpha exp %0d got %0d", want.alpha, got.alpha); errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Directed: axis extremes, truncation around zero, off-canvas edges.
  task automatic test_extremes();
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(-131072, 131071, 1023, 2047));
    send_sample(make_sample(131071, -131072, 1, 5));
    send_sample(make_sample(-63, 63, 2, 3));
    send_sample(make_sample(-64, 64, 3, 4));
    send_sample(make_sample(32767, -32767, 4, 6));
    send_sample(make_sample(32768, -32768, 5, 7));
    send_sample(make_sample(-32768, 32768, 6, 8));
    send_sample(make_sample(-32832, 32832, 7, 9));
    drain();
  endtask

  // Directed: area bounds incl. reversed and single column/line.
  task automatic test_area();
    write_area(100, 200, 10, 20);
    send_sample(make_sample(0, 0, 10, 99));
    send_sample(make_sample(0, 0, 10, 100));
    send_sample(make_sample(0, 0, 20, 200));
    send_sample(make_sample(0, 0, 21, 150));
    drain();
    write_area(300, 50, 700, 3);   // reversed: single column and line
    send_sample(make_sample(640, 640, 700, 300));
    send_sample(make_sample(640, 640, 700, 301));
    send_sample(make_sample(640, 640, 699, 300));
    drain();
    write_area(2047, 2047, 1023, 1023);
    send_sample(make_sample(100, -100, 1023, 2047));
    drain();
    write_area(0, 2047, 0, 1023);
  endtask

  // Directed: every field select and fixed colour mode, then multicolour.
  task automatic test_colour_modes();
    for (int f = 0; f < 4; f++) begin
      write_reg(REG_FIELD_SELECT, 17'(f));
      for (int m = 0; m < 4; m++) begin
        write_reg(REG_PLOT_MODE, 17'(m));
        send_sample(make_sample(1000, 2000, 8, 1));
        send_sample(make_sample(-1000, -2000, 9, 1));
        drain();
      end
    end
    write_reg(REG_FIELD_SELECT, 17'(0));
    write_reg(REG_PLOT_MODE, 17'(4));
    write_reg(REG_IRE_RANGE, 17'(-65535));
    send_sample(make_sample(5000, 5000, 0, 0));
    drain();
    write_reg(REG_IRE_RANGE, 17'(1));
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(-32768, 32767, 0, 0));
    drain();
    write_reg(REG_IRE_RANGE, 17'(65535));
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(32767, 32767, 0, 0));
    drain();
  endtask

  // Random phases under random register settings, with extremes mixed in.
  task automatic test_random_phases();
    int ire;
    for (int ph = 0; ph < 30; ph++) begin
      if (ph % 3 == 0)
        write_area(0, 2047, 0, 1023);
      else
        write_area($urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
      write_reg(REG_FIELD_SELECT, 17'($urandom_range(0, 3)));
      write_reg(REG_PLOT_MODE, 17'($urandom_range(0, 7)));
      case ($urandom_range(0, 4))
        0: ire = 65535;
        1: ire = -$urandom_range(0, 65535);
        2: ire = $urandom_range(1, 300);
        default: ire = $urandom_range(1, 65535);
      endcase
      write_reg(REG_IRE_RANGE, 17'(ire));
      // Occasional out-of-list index must be ignored.
      if (ph % 7 == 6) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= 3'd7;
        cfg_ch.data  <= 17'($urandom);
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
      end
      if (sh_mode[2]) multi_points += 60;
      no_stall = (ph % 5 == 4);
      for (int i = 0; i < 60; i++) begin
        send_sample(rand_sample(), !no_stall);
      end
      drain();
      no_stall = 1'b0;
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    points_plotted = 0;
    multi_points = 0;
    no_stall = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.chroma_u = '0;
    in_ch.chroma_v = '0;
    in_ch.line_index = '0;
    in_ch.column_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sh_x_first = 0; sh_x_last = 2047;
    sh_y_first = 0; sh_y_last = 1023;
    sh_field = 0; sh_mode = 0; sh_ire = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_area();
    test_colour_modes();
    test_random_phases();
    drain();
    $display("Sent %0d sample words, %0d plotted; about %0d under multicolour.",
             words_sent, points_plotted, multi_points);
    $display("Area, field, blend, density and IRE range settings varied per phase.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* vectorscope_point_mapper_top.f */
+incdir+hdl
hdl/vspm_pkg.sv
hdl/vspm_ifs.sv
hdl/vspm_front.sv
hdl/vspm_queue.sv
hdl/vspm_back.sv
hdl/vectorscope_point_mapper_top.sv
verif/vspm_tb_pkg.sv
verif/tb.sv
